// File: src/kgsr_pkg.sv
// ---------------------------------------------------------------------------
// kgsr_pkg
// Shared widths, types and defaults for the k-group stream reverser.
// ---------------------------------------------------------------------------
package kgsr_pkg;

    localparam int VALUE_W       = 32;
    localparam int GS_W          = 5;
    localparam int MAX_GROUP_DEF = 16;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_seq_state;

    // read request issued toward the output stage, one per drained beat
    typedef struct packed {
        logic issue;
        logic run_last;
        logic list_end;
    } t_rd_req;

endpackage

// File: src/kgsr_ifs.sv
// ---------------------------------------------------------------------------
// kgsr interfaces
// Valid/ready channels for input beats, result beats and the config write.
// ---------------------------------------------------------------------------
interface kgsr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [kgsr_pkg::VALUE_W-1:0] value;
    logic                                list_last;

    modport source (output valid, output value, output list_last, input ready);
    modport sink   (input valid, input value, input list_last, output ready);
endinterface

interface kgsr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kgsr_pkg::VALUE_W-1:0] out_value;
    logic                                run_last;
    logic                                list_end;

    modport source (output valid, output out_value, output run_last, output list_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input list_end,
                    output ready);
endinterface

interface kgsr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [kgsr_pkg::GS_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/kgsr_mem.sv
// ---------------------------------------------------------------------------
// kgsr_mem
// Group buffer: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module kgsr_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [kgsr_pkg::VALUE_W-1:0] i_wdata,
    input  logic                                i_re,
    input  logic [AW-1:0]                       i_raddr,
    output logic signed [kgsr_pkg::VALUE_W-1:0] o_rdata
);
    import kgsr_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data unless a new read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kgsr_seq.sv
// ---------------------------------------------------------------------------
// kgsr_seq
// Fill counter, group size register and drain sequencer for the buffer.
// ---------------------------------------------------------------------------
module kgsr_seq #(
    parameter int MAX_GROUP = 16,
    parameter int AW        = $clog2(MAX_GROUP),
    parameter int FCW       = $clog2(MAX_GROUP + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kgsr_in_if.sink                             in_ch,
    kgsr_cfg_if.sink                            cfg_ch,
    input  logic                                i_adv,
    output logic                                o_we,
    output logic [AW-1:0]                       o_waddr,
    output logic signed [kgsr_pkg::VALUE_W-1:0] o_wdata,
    output logic [AW-1:0]                       o_raddr,
    output kgsr_pkg::t_rd_req                   o_req
);
    import kgsr_pkg::*;

    localparam int CMPW = (FCW > GS_W) ? FCW : GS_W;

    t_seq_state       r_state, n_state;
    logic [FCW-1:0]   r_fill, n_fill;
    logic [FCW-1:0]   r_left, n_left;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_rev, n_rev;
    logic             r_last, n_last;
    logic [GS_W-1:0]  r_gs;

    logic [CMPW-1:0]  gs_x;
    logic [CMPW-1:0]  eff;
    logic [CMPW-1:0]  cnt;
    logic             accept;
    logic             full_grp;
    logic             trig;
    logic             issue;
    logic             final_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs <= GS_W'(1);
        end else if (cfg_ch.valid) begin
            r_gs <= cfg_ch.data;
        end
    end
    assign cfg_ch.ready = 1'b1;

    // zero acts as one, anything past the buffer depth saturates
    always_comb begin
        gs_x = CMPW'(r_gs);
        if (r_gs == '0) begin
            eff = CMPW'(1);
        end else if (gs_x > CMPW'(MAX_GROUP)) begin
            eff = CMPW'(MAX_GROUP);
        end else begin
            eff = gs_x;
        end
    end

    assign in_ch.ready = (r_state == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign cnt         = CMPW'(r_fill) + CMPW'(1);
    assign full_grp    = (cnt >= eff);
    assign trig        = full_grp || in_ch.list_last;
    assign issue       = (r_state == ST_DRAIN) && i_adv;
    assign final_beat  = (r_left == FCW'(1));

    assign o_we    = accept;
    assign o_waddr = r_fill[AW-1:0];
    assign o_wdata = in_ch.value;
    assign o_raddr = r_addr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && trig) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (issue && final_beat) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_fill = r_fill;
        n_left = r_left;
        n_addr = r_addr;
        n_rev  = r_rev;
        n_last = r_last;
        o_req  = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (trig) begin
                        n_fill = '0;
                        n_left = cnt[FCW-1:0];
                        n_rev  = full_grp;
                        n_last = in_ch.list_last;
                        n_addr = full_grp ? r_fill[AW-1:0] : '0;
                    end else begin
                        n_fill = cnt[FCW-1:0];
                    end
                end
            end
            ST_DRAIN: begin
                o_req.issue    = issue;
                o_req.run_last = final_beat;
                o_req.list_end = final_beat && r_last;
                if (issue) begin
                    n_left = r_left - FCW'(1);
                    n_addr = r_rev ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_rev  <= n_rev;
        r_last <= n_last;
    end

    a_fill_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FCW'(MAX_GROUP))
        else $error("fill count reached buffer depth");

    a_drain_has_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_left != '0) && (r_fill == '0))
        else $error("drain with no beats left or buffer not reset");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && final_beat) |=> (r_state == ST_IDLE))
        else $error("drain did not end after final beat");

endmodule

// File: src/kgsr_out.sv
// ---------------------------------------------------------------------------
// kgsr_out
// Read-pending stage and output register for drained result beats.
// ---------------------------------------------------------------------------
module kgsr_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kgsr_pkg::t_rd_req                   i_req,
    input  logic signed [kgsr_pkg::VALUE_W-1:0] i_rdata,
    output logic                                o_adv,
    kgsr_out_if.source                          out_ch
);
    import kgsr_pkg::*;

    logic                r_p_valid;
    logic                r_p_run_last;
    logic                r_p_list_end;
    logic                r_o_valid;
    logic signed [VALUE_W-1:0] r_o_value;
    logic                r_o_run_last;
    logic                r_o_list_end;
    logic                out_free;

    assign out_free = !r_o_valid || out_ch.ready;
    assign o_adv    = !r_p_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_p_valid <= i_req.issue;
            end
            if (out_free) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_p_run_last <= i_req.run_last;
            r_p_list_end <= i_req.list_end;
        end
        if (out_free) begin
            r_o_value    <= i_rdata;
            r_o_run_last <= r_p_run_last;
            r_o_list_end <= r_p_list_end;
        end
    end

    assign out_ch.valid     = r_o_valid;
    assign out_ch.out_value = r_o_value;
    assign out_ch.run_last  = r_o_run_last;
    assign out_ch.list_end  = r_o_list_end;

    a_issue_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.issue |-> o_adv)
        else $error("read issued while pending stage is blocked");

    a_pending_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !o_adv) |=> r_p_valid && $stable(r_p_run_last)
                                  && $stable(r_p_list_end) && $stable(i_rdata))
        else $error("pending beat lost while blocked");

endmodule

// File: src/k_group_stream_reverser.sv
// ---------------------------------------------------------------------------
// k_group_stream_reverser
// Buffers values into groups, emits full groups reversed, a short tail in order.
// ---------------------------------------------------------------------------
// Result path: the closing beat starts the drain, and each drained beat passes the
//   buffer read register and pending stage, then the output register. Throughput:
//   one input beat per cycle while a group fills, none until it drains; results
//   leave at one beat per cycle while the sink is ready, limited by one read port.
// Reset: fill count and sequencer clear, group size returns to 1; the buffer
//   itself is not cleared and needs no clearing pass.
module k_group_stream_reverser #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kgsr_in_if.sink    i_in,
    kgsr_cfg_if.sink   i_cfg,
    kgsr_out_if.source o_out
);
    import kgsr_pkg::*;

    localparam int AW  = $clog2(MAX_GROUP);
    localparam int FCW = $clog2(MAX_GROUP + 1);

    logic                      we;
    logic [AW-1:0]             waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [AW-1:0]             raddr;
    logic signed [VALUE_W-1:0] rdata;
    logic                      adv;
    t_rd_req                   req;

    kgsr_seq #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW),
        .FCW       (FCW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (i_in),
        .cfg_ch  (i_cfg),
        .i_adv   (adv),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .o_req   (req)
    );

    kgsr_mem #(
        .DEPTH (MAX_GROUP),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (req.issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    kgsr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_rdata (rdata),
        .o_adv   (adv),
        .out_ch  (o_out)
    );

endmodule

// File: tb/sv/k_group_stream_reverser_tb.sv
// ---------------------------------------------------------------------------
// k_group_stream_reverser_tb
// Streams lists through the group reverser under random source gaps and sink
// stalls. The group size is changed between phases. Every result beat is
// checked against a local prediction of the group buffer.
// ---------------------------------------------------------------------------
module k_group_stream_reverser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kgsr_pkg::*;

    localparam int MAX_GROUP   = MAX_GROUP_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;
    localparam int END_WAIT    = 24;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_BEATS = 34;

    typedef enum int {
        IDLE_RANDOM,
        IDLE_NONE,
        IDLE_SPARSE
    } t_idle_mode;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      list_last;
        int unsigned               gap;
        bit                        wait_drain;
    } t_in_beat;

    typedef struct {
        logic signed [VALUE_W-1:0] out_value;
        logic                      run_last;
        logic                      list_end;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kgsr_in_if  in_if ();
    kgsr_out_if out_if ();
    kgsr_cfg_if cfg_if ();

    k_group_stream_reverser #(
        .MAX_GROUP (MAX_GROUP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's state
    logic [VALUE_W-1:0] grp_buf [MAX_GROUP];
    int unsigned        grp_fill;
    logic [GS_W-1:0]    grp_size;

    t_in_beat   beats_to_send [$];
    t_result    results_due [$];
    t_in_beat   cur_beat;
    t_result    due_r;
    int unsigned src_waited;
    int unsigned sink_left;
    int unsigned sink_n;
    t_idle_mode gap_mode;
    t_idle_mode stall_mode;
    int          error_count;
    int unsigned cycle_count;

    function automatic int unsigned eff_size(logic [GS_W-1:0] g);
        if (g == '0) return 1;
        if (g > MAX_GROUP) return MAX_GROUP;
        return g;
    endfunction

    function automatic int unsigned draw_wait(t_idle_mode m);
        case (m)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default:     return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // push one accepted beat into the shadow buffer and queue what it releases
    function automatic void reorder_beat(t_in_beat b);
        int unsigned gs;
        int unsigned n;
        bit          rev;
        t_result     r;
        gs = eff_size(grp_size);
        if (grp_fill < MAX_GROUP) begin
            grp_buf[grp_fill] = b.value;
            grp_fill++;
        end
        if (grp_fill >= gs) begin
            rev = 1'b1;
        end else if (b.list_last) begin
            rev = 1'b0;
        end else begin
            return;
        end
        n = grp_fill;
        for (int unsigned i = 0; i < n; i++) begin
            r.out_value = grp_buf[rev ? (n - 1 - i) : i];
            r.run_last  = (i + 1 == n);
            r.list_end  = b.list_last && (i + 1 == n);
            results_due.push_back(r);
        end
        grp_fill = 0;
    endfunction

    task automatic push_beat(logic [VALUE_W-1:0] v, logic last, bit hold);
        t_in_beat b;
        b.value      = v;
        b.list_last  = last;
        b.gap        = draw_wait(gap_mode);
        b.wait_drain = hold;
        beats_to_send.push_back(b);
    endtask

    // wait out the source queue, the pending results and the drain tail;
    // sample on the falling edge so the rising edge's updates have settled
    task automatic wait_idle();
        while (beats_to_send.size() != 0 || in_if.valid) @(negedge i_clk);
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_group_size(logic [GS_W-1:0] g);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= g;
        @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready)) @(posedge i_clk);
        grp_size = g;
        cfg_if.valid <= 1'b0;
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.value     <= '0;
            in_if.list_last <= 1'b0;
            src_waited      <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                reorder_beat(cur_beat);
            end
            if (beats_to_send.size() != 0 && src_waited >= beats_to_send[0].gap &&
                !(beats_to_send[0].wait_drain && results_due.size() != 0)) begin
                cur_beat        = beats_to_send.pop_front();
                in_if.valid     <= 1'b1;
                in_if.value     <= cur_beat.value;
                in_if.list_last <= cur_beat.list_last;
                src_waited      <= 0;
            end else begin
                in_if.valid <= 1'b0;
                if (beats_to_send.size() != 0) begin
                    src_waited <= src_waited + 1;
                end
            end
        end
    end

    // sink side: check each accepted beat, then draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            sink_left    <= 0;
        end else begin
            sink_n = sink_left;
            if (out_if.valid && out_if.ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: out_value=%h run_last=%b list_end=%b",
                           out_if.out_value, out_if.run_last, out_if.list_end);
                    error_count++;
                end else begin
                    due_r = results_due.pop_front();
                    if (out_if.out_value !== due_r.out_value) begin
                        $error("out_value: expected %h, got %h",
                               due_r.out_value, out_if.out_value);
                        error_count++;
                    end
                    if (out_if.run_last !== due_r.run_last) begin
                        $error("run_last: expected %b, got %b",
                               due_r.run_last, out_if.run_last);
                        error_count++;
                    end
                    if (out_if.list_end !== due_r.list_end) begin
                        $error("list_end: expected %b, got %b",
                               due_r.list_end, out_if.list_end);
                        error_count++;
                    end
                end
                sink_n = draw_wait(stall_mode);
            end
            if (sink_n == 0) begin
                out_if.ready <= 1'b1;
                sink_left    <= 0;
            end else begin
                out_if.ready <= 1'b0;
                sink_left    <= sink_n - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("k_group_stream_reverser: mismatch");
            $finish;
        end
    end

    initial begin
        logic [GS_W-1:0] phase_gs [NUM_PHASES];
        int unsigned     sent;
        int unsigned     len;
        int unsigned     hold_at;
        int unsigned     eff;
        bit              noisy;
        logic            last;

        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        in_if.list_last = 1'b0;
        out_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        error_count     = 0;
        cycle_count     = 0;
        grp_fill        = 0;
        grp_size        = 5'd1;
        gap_mode        = IDLE_RANDOM;
        stall_mode      = IDLE_RANDOM;
        for (int i = 0; i < MAX_GROUP; i++) grp_buf[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset group size: straight pass, value extremes
        push_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h8000_0000, 1'b0, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_beat(32'h0000_0000, 1'b0, 1'b0);

        // list end on a complete group, then on a short tail
        write_group_size(5'd4);
        push_beat(32'h0000_0001, 1'b0, 1'b0);
        push_beat(32'h8000_0000, 1'b0, 1'b0);
        push_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_beat(32'h0000_0011, 1'b0, 1'b0);
        push_beat(32'h0000_0012, 1'b0, 1'b0);
        push_beat(32'h0000_0013, 1'b1, 1'b0);

        // zero group size acts as one
        write_group_size(5'd0);
        push_beat(32'hA5A5_A5A5, 1'b0, 1'b0);
        push_beat(32'h5A5A_5A5A, 1'b1, 1'b0);

        // lower the size while a group is part full
        write_group_size(5'd8);
        for (int i = 0; i < 5; i++) push_beat(draw_value(), 1'b0, 1'b0);
        write_group_size(5'd2);
        push_beat(draw_value(), 1'b0, 1'b0);

        phase_gs = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd0, 5'd0, 5'd0, 5'd7};
        for (int p = 6; p < 9; p++) phase_gs[p] = GS_W'($urandom_range(0, 31));

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_group_size(phase_gs[p]);
            gap_mode   = t_idle_mode'(p % 3);
            stall_mode = t_idle_mode'((p + 1) % 3);
            eff        = eff_size(phase_gs[p]);
            hold_at    = $urandom_range(5, PHASE_BEATS - 6);
            sent       = 0;
            while (sent < PHASE_BEATS) begin
                // mostly whole lists; some with list_last scattered at random
                noisy = ($urandom_range(0, 4) == 0);
                len   = $urandom_range(1, 2 * eff + 2);
                for (int unsigned j = 0; j < len; j++) begin
                    last = noisy ? ($urandom_range(0, 3) == 0) : (j + 1 == len);
                    push_beat(draw_value(), last, sent == hold_at);
                    sent++;
                end
            end
            // leave a part-filled group for the next size to meet
            if ($urandom_range(0, 1) == 1) begin
                len = $urandom_range(1, 3);
                for (int unsigned j = 0; j < len; j++) push_beat(draw_value(), 1'b0, 1'b0);
            end
        end

        // flush whatever group is still open
        push_beat(draw_value(), 1'b1, 1'b0);
        while (beats_to_send.size() != 0 || in_if.valid) @(negedge i_clk);
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("k_group_stream_reverser: match");
        end else begin
            $display("k_group_stream_reverser: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
src/kgsr_pkg.sv
src/kgsr_ifs.sv
src/kgsr_mem.sv
src/kgsr_seq.sv
src/kgsr_out.sv
src/k_group_stream_reverser.sv
tb/sv/k_group_stream_reverser_tb.sv
